// ===== rtl/pts_pkg.sv =====
// Package for the periodic task tick scheduler.
// Request and status codes, handle select codes, table entry type and the
// command / status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pts_pkg;

    // At most this many result words per tick; later firings are not reported.
    localparam int RESULT_CAP = 16;
    localparam int NFW        = $clog2(RESULT_CAP + 1);

    typedef enum logic [1:0] {
        REQ_REG   = 2'd0,
        REQ_UNREG = 2'd1,
        REQ_TICK  = 2'd2
    } t_req;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_FIRED     = 3'd1,
        ST_FULL      = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_IDLE      = 3'd4
    } t_status;

    // Source of the handle field of an emitted word.
    typedef enum logic [1:0] {
        HS_REQ  = 2'd0,
        HS_PEND = 2'd1,
        HS_ZERO = 2'd2
    } t_hsel;

    typedef struct packed {
        logic [7:0]  handle;
        logic [15:0] interval;
        logic [15:0] count;
    } t_entry;

    typedef struct packed {
        logic    cap;        // capture the request
        logic    idx_clr;
        logic    idx_inc;
        logic    rd;         // read table into the read register
        logic    rd_next;    // read at idx+1 instead of idx
        logic    append;     // write request at the end, count up
        logic    shift;      // write read register back at idx
        logic    used_dec;
        logic    tick_step;  // update counter at idx, handle a firing
        logic    emit;
        t_status emit_status;
        t_hsel   emit_hsel;
        logic    emit_last;
    } t_cmd;

    typedef struct packed {
        logic [1:0] req_type;
        logic       full;
        logic       empty;
        logic       match;
        logic       nxt_lt_used;   // idx+1 < used
        logic       nxt2_lt_used;  // idx+2 < used
        logic       take_emit;     // this entry fires and pushes out the pending word
        logic       pend_valid;
        logic       out_free;
    } t_stat;

endpackage

`default_nettype wire

// ===== rtl/pts_if.sv =====
// Handshake channels of the periodic task tick scheduler: request and result.
// Depends on nothing; payload widths are fixed by the field definitions.
`timescale 1ns / 1ps
`default_nettype none

interface pts_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [7:0]  task_handle;
    logic [15:0] interval_ticks;

    modport source (output valid, output req_type, output task_handle,
                    output interval_ticks, input ready);
    modport sink   (input valid, input req_type, input task_handle,
                    input interval_ticks, output ready);
endinterface

interface pts_res_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [7:0] fired_handle;
    logic       last;

    modport source (output valid, output status, output fired_handle,
                    output last, input ready);
    modport sink   (input valid, input status, input fired_handle,
                    input last, output ready);
endinterface

`default_nettype wire

// ===== rtl/pts_datapath.sv =====
// Datapath of the scheduler: task table memory, fill count, scan index,
// pending fired handle and the output word register. Uses pts_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pts_datapath #(
    parameter int MAX_TASKS = 16
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire pts_pkg::t_cmd  i_cmd,
    output pts_pkg::t_stat      o_stat,
    input  wire logic [1:0]     i_req_type,
    input  wire logic [7:0]     i_task_handle,
    input  wire logic [15:0]    i_interval_ticks,
    input  wire logic           i_out_ready,
    output logic                o_out_valid,
    output logic [2:0]          o_status,
    output logic [7:0]          o_fired_handle,
    output logic                o_last
);
    import pts_pkg::*;

    localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CW = $clog2(MAX_TASKS + 1);
    localparam int SW = CW + 1;

    t_entry          r_mem [MAX_TASKS];
    t_entry          r_rdata;

    logic [1:0]      r_req;
    logic [7:0]      r_handle;
    logic [15:0]     r_ivl;

    logic [CW-1:0]   r_used;
    logic [IW-1:0]   r_idx;
    logic [NFW-1:0]  r_nfire;
    logic            r_pend_valid;
    logic [7:0]      r_pend_handle;

    logic            r_out_valid;
    t_status         r_out_status;
    logic [7:0]      r_out_handle;
    logic            r_out_last;

    logic [SW-1:0]   w_idx_p1;
    logic [SW-1:0]   w_idx_p2;
    logic [IW-1:0]   w_rd_addr;
    logic [16:0]     w_cnt_p1;
    logic            w_fire;
    logic            w_take;
    logic            w_out_free;
    logic [7:0]      w_emit_handle;

    assign w_idx_p1   = SW'(r_idx) + SW'(1);
    assign w_idx_p2   = SW'(r_idx) + SW'(2);
    assign w_rd_addr  = i_cmd.rd_next ? w_idx_p1[IW-1:0] : r_idx;
    assign w_cnt_p1   = {1'b0, r_rdata.count} + 17'd1;
    assign w_fire     = (w_cnt_p1 >= {1'b0, r_rdata.interval});
    assign w_take     = w_fire && (r_nfire != NFW'(RESULT_CAP));
    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        case (i_cmd.emit_hsel)
            HS_REQ:  w_emit_handle = r_handle;
            HS_PEND: w_emit_handle = r_pend_handle;
            default: w_emit_handle = 8'd0;
        endcase
    end

    always_comb begin
        o_stat.req_type     = r_req;
        o_stat.full         = (r_used == CW'(MAX_TASKS));
        o_stat.empty        = (r_used == '0);
        o_stat.match        = (r_rdata.handle == r_handle);
        o_stat.nxt_lt_used  = (w_idx_p1 < SW'(r_used));
        o_stat.nxt2_lt_used = (w_idx_p2 < SW'(r_used));
        o_stat.take_emit    = w_take && r_pend_valid;
        o_stat.pend_valid   = r_pend_valid;
        o_stat.out_free     = w_out_free;
    end

    // Table memory: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (i_cmd.append) begin
            r_mem[r_used[IW-1:0]] <= '{handle: r_handle, interval: r_ivl, count: 16'd0};
        end else if (i_cmd.tick_step) begin
            r_mem[r_idx] <= '{handle:   r_rdata.handle,
                              interval: r_rdata.interval,
                              count:    w_fire ? 16'd0 : w_cnt_p1[15:0]};
        end else if (i_cmd.shift) begin
            r_mem[r_idx] <= r_rdata;
        end
        if (i_cmd.rd) begin
            r_rdata <= r_mem[w_rd_addr];
        end
    end

    // Request capture and pending handle
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_req    <= i_req_type;
            r_handle <= i_task_handle;
            r_ivl    <= i_interval_ticks;
        end
        if (i_cmd.tick_step && w_take) begin
            r_pend_handle <= r_rdata.handle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used       <= '0;
            r_idx        <= '0;
            r_nfire      <= '0;
            r_pend_valid <= 1'b0;
        end else begin
            if (i_cmd.append) begin
                r_used <= r_used + CW'(1);
            end else if (i_cmd.used_dec) begin
                r_used <= r_used - CW'(1);
            end
            if (i_cmd.idx_clr) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + IW'(1);
            end
            if (i_cmd.cap) begin
                r_nfire      <= '0;
                r_pend_valid <= 1'b0;
            end else if (i_cmd.tick_step && w_take) begin
                r_nfire      <= r_nfire + NFW'(1);
                r_pend_valid <= 1'b1;
            end
        end
    end

    // Output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.emit || (i_cmd.tick_step && w_take && r_pend_valid)) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (i_cmd.emit) begin
            r_out_status <= i_cmd.emit_status;
            r_out_handle <= w_emit_handle;
            r_out_last   <= i_cmd.emit_last;
        end else if (i_cmd.tick_step && w_take && r_pend_valid) begin
            // a newer firing pushes the earlier one out, not the final word
            r_out_status <= ST_FIRED;
            r_out_handle <= r_pend_handle;
            r_out_last   <= 1'b0;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out_status;
    assign o_fired_handle = r_out_handle;
    assign o_last         = r_out_last;

endmodule

`default_nettype wire

// ===== rtl/pts_ctrl.sv =====
// Controller of the scheduler: sequences register, unregister (scan and
// compaction) and tick (table walk) over the datapath. Uses pts_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pts_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire pts_pkg::t_stat i_stat,
    output pts_pkg::t_cmd      o_cmd
);
    import pts_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISP,
        S_FIN,
        S_URD,
        S_UEV,
        S_SRD,
        S_SEV,
        S_TRD,
        S_TEV,
        S_TEND
    } t_state;

    t_state  r_state;
    t_state  n_state;
    t_status r_fin_status;
    t_status n_fin_status;
    t_hsel   r_fin_hsel;
    t_hsel   n_fin_hsel;

    // nothing is taken while reset is held
    assign o_in_ready = (r_state == S_IDLE) && i_rst_n;

    always_comb begin
        o_cmd        = '0;
        n_state      = r_state;
        n_fin_status = r_fin_status;
        n_fin_hsel   = r_fin_hsel;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.cap     = 1'b1;
                    o_cmd.idx_clr = 1'b1;
                    n_state       = S_DISP;
                end
            end
            S_DISP: begin
                n_fin_hsel = HS_REQ;
                n_state    = S_FIN;
                case (i_stat.req_type)
                    REQ_REG: begin
                        if (i_stat.full) begin
                            n_fin_status = ST_FULL;
                        end else begin
                            o_cmd.append = 1'b1;
                            n_fin_status = ST_OK;
                        end
                    end
                    REQ_UNREG: begin
                        n_fin_status = ST_NOT_FOUND;
                        if (!i_stat.empty) begin
                            n_state = S_URD;
                        end
                    end
                    REQ_TICK: begin
                        n_state = i_stat.empty ? S_TEND : S_TRD;
                    end
                    default: begin
                        n_fin_status = ST_NOT_FOUND;
                        n_fin_hsel   = HS_ZERO;
                    end
                endcase
            end
            S_FIN: begin
                if (i_stat.out_free) begin
                    o_cmd.emit        = 1'b1;
                    o_cmd.emit_status = r_fin_status;
                    o_cmd.emit_hsel   = r_fin_hsel;
                    o_cmd.emit_last   = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            S_URD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_UEV;
            end
            S_UEV: begin
                if (i_stat.match) begin
                    n_fin_status = ST_OK;
                    if (i_stat.nxt_lt_used) begin
                        n_state = S_SRD;
                    end else begin
                        o_cmd.used_dec = 1'b1;
                        n_state        = S_FIN;
                    end
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = i_stat.nxt_lt_used ? S_URD : S_FIN;
                end
            end
            S_SRD: begin
                o_cmd.rd      = 1'b1;
                o_cmd.rd_next = 1'b1;
                n_state       = S_SEV;
            end
            S_SEV: begin
                o_cmd.shift   = 1'b1;
                o_cmd.idx_inc = 1'b1;
                if (i_stat.nxt2_lt_used) begin
                    n_state = S_SRD;
                end else begin
                    o_cmd.used_dec = 1'b1;
                    n_state        = S_FIN;
                end
            end
            S_TRD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_TEV;
            end
            S_TEV: begin
                // hold the entry while an earlier fired word still waits
                if (!(i_stat.take_emit && !i_stat.out_free)) begin
                    o_cmd.tick_step = 1'b1;
                    o_cmd.idx_inc   = 1'b1;
                    n_state         = i_stat.nxt_lt_used ? S_TRD : S_TEND;
                end
            end
            S_TEND: begin
                if (i_stat.out_free) begin
                    o_cmd.emit        = 1'b1;
                    o_cmd.emit_status = i_stat.pend_valid ? ST_FIRED : ST_IDLE;
                    o_cmd.emit_hsel   = i_stat.pend_valid ? HS_PEND : HS_ZERO;
                    o_cmd.emit_last   = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_fin_status <= n_fin_status;
        r_fin_hsel   <= n_fin_hsel;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/periodic_task_tick_scheduler.sv =====
// Top level of the periodic task tick scheduler.
// Joins pts_ctrl and pts_datapath to the request and result channels
// (pts_req_if, pts_res_if). Uses pts_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Keeps an ordered table of up to MAX_TASKS periodic tasks in a single-port
// read / single-port write memory and serves one request at a time. Every
// table access is a read step followed by an evaluate / write-back step; a
// tick walks all used entries, an unregister scans up to the match, then
// compacts the entries behind it.
// Result words leave through an output register; the walk pauses on a
// firing entry while an earlier fired word still waits there. A tick reports
// at most 16 fired handles, the last word of every request carries last = 1.

module periodic_task_tick_scheduler #(
    parameter int MAX_TASKS = 16
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    pts_req_if.sink    i_req,
    pts_res_if.source  o_res
);
    import pts_pkg::*;

    t_cmd w_cmd;
    t_stat w_stat;
    logic w_in_ready;

    assign i_req.ready = w_in_ready;

    pts_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (w_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    pts_datapath #(
        .MAX_TASKS (MAX_TASKS)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_stat           (w_stat),
        .i_req_type       (i_req.req_type),
        .i_task_handle    (i_req.task_handle),
        .i_interval_ticks (i_req.interval_ticks),
        .i_out_ready      (o_res.ready),
        .o_out_valid      (o_res.valid),
        .o_status         (o_res.status),
        .o_fired_handle   (o_res.fired_handle),
        .o_last           (o_res.last)
    );

endmodule

`default_nettype wire

// ===== rtl/pts_checker.sv =====
// Port-level checker for the periodic task tick scheduler, bound to the top.
// Uses pts_pkg for status codes.
`timescale 1ns / 1ps
`default_nettype none

module pts_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       i_in_ready,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic [2:0] i_status,
    input wire logic [7:0] i_handle,
    input wire logic       i_last
);
    import pts_pkg::*;

    // only fired words can be followed by more words of the same request
    a_nonlast_is_fired: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_last |-> i_status == ST_FIRED)
        else $error("non-final word without fired status");

    a_idle_zero_handle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status == ST_IDLE |-> i_handle == 8'd0 && i_last)
        else $error("idle tick word malformed");

    // one request at a time: no second accept right after one
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("request taken while previous one in flight");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_status)
            && $stable(i_handle) && $stable(i_last))
        else $error("stalled result word changed");

endmodule

bind periodic_task_tick_scheduler pts_checker u_pts_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_req.valid),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_status    (o_res.status),
    .i_handle    (o_res.fired_handle),
    .i_last      (o_res.last)
);

`default_nettype wire
